// File: hdl/dictionary_line_field_splitter_core_assert.svh
// Assertion macros used by the dictionary line field splitter parser.
`ifndef DICTIONARY_LINE_FIELD_SPLITTER_CORE_ASSERT_SVH
`define DICTIONARY_LINE_FIELD_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DLFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DLFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dlfs_pkg.sv
// Package with widths, character codes, parse phases and beat types of the splitter.
package dlfs_pkg;

    localparam int CHAR_W = 16;
    localparam int POS_W  = 24;

    localparam longint BUFFER_CHARS = 64'd16777216;
    localparam bit BUF_END_REACHABLE = (BUFFER_CHARS <= (64'd1 << POS_W));
    localparam logic [POS_W-1:0] BUF_LAST_POS = POS_W'(BUFFER_CHARS - 64'd1);

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_HASH    = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_OPEN    = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_CLOSE   = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 16'h002F;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_OPEN,
        PH_CLOSE,
        PH_SLASH,
        PH_SLASH2,
        PH_ENGLISH
    } dlfs_phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_in_buffer;
    } dlfs_char_t;

    typedef struct packed {
        logic [POS_W-1:0] entry_start;
        logic [POS_W-1:0] headword_end;
        logic [POS_W-1:0] pinyin_start;
        logic [POS_W-1:0] pinyin_end;
        logic [POS_W-1:0] english_start;
        logic [POS_W-1:0] english_end;
        logic [POS_W-1:0] line_end;
    } dlfs_result_t;

endpackage

// File: hdl/dlfs_if.sv
// Valid/ready channel interfaces for character beats and entry beats.
interface dlfs_char_if
    import dlfs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_in_buffer;

    modport source (output valid, output character, output last_in_buffer, input ready);
    modport sink   (input valid, input character, input last_in_buffer, output ready);
endinterface

interface dlfs_entry_if
    import dlfs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] entry_start;
    logic [POS_W-1:0] headword_end;
    logic [POS_W-1:0] pinyin_start;
    logic [POS_W-1:0] pinyin_end;
    logic [POS_W-1:0] english_start;
    logic [POS_W-1:0] english_end;
    logic [POS_W-1:0] line_end;

    modport source (output valid, output entry_start, output headword_end,
                    output pinyin_start, output pinyin_end, output english_start,
                    output english_end, output line_end, input ready);
    modport sink   (input valid, input entry_start, input headword_end,
                    input pinyin_start, input pinyin_end, input english_start,
                    input english_end, input line_end, output ready);
endinterface

// File: hdl/dlfs_in_stage.sv
// Input register holding one character beat ahead of the parser.
module dlfs_in_stage
    import dlfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dlfs_char_if.sink   chars,
    input  logic        advance,
    output logic        held_valid,
    output dlfs_char_t  held
);

    logic       valid_reg;
    dlfs_char_t data_reg;

    assign chars.ready = !valid_reg || advance;
    assign held_valid  = valid_reg;
    assign held        = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            data_reg <= '{character: chars.character, last_in_buffer: chars.last_in_buffer};
        end
    end

endmodule

// File: hdl/dlfs_parser.sv
// Line parser: position counter, parse phase and saved field positions.
`include "dictionary_line_field_splitter_core_assert.svh"

module dlfs_parser
    import dlfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  dlfs_char_t   beat,
    output logic         emit,
    output dlfs_result_t result
);

    dlfs_phase_t      phase_reg, phase_next;
    logic             als_reg, als_next;
    logic             cm_reg, cm_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] ls_reg, ls_next;
    logic [POS_W-1:0] hw_end_reg, hw_end_next;
    logic [POS_W-1:0] py_start_reg, py_start_next;
    logic [POS_W-1:0] py_end_reg, py_end_next;
    logic [POS_W-1:0] en_start_reg, en_start_next;
    logic [POS_W-1:0] en_end_reg, en_end_next;

    logic             last;
    logic             is_nl;
    logic             finish;
    dlfs_phase_t      phase_cur;
    logic [POS_W-1:0] p_inc;
    logic [POS_W-1:0] line_end;

    always_comb
    begin
        p_inc = pos_reg + POS_W'(1);
        last  = beat.last_in_buffer || (BUF_END_REACHABLE && (pos_reg == BUF_LAST_POS));
        is_nl = (beat.character == CH_NEWLINE);

        phase_cur     = phase_reg;
        als_next      = als_reg;
        cm_next       = cm_reg;
        ls_next       = ls_reg;
        hw_end_next   = hw_end_reg;
        py_start_next = py_start_reg;
        py_end_next   = py_end_reg;
        en_start_next = en_start_reg;
        en_end_next   = en_end_reg;
        finish        = 1'b0;
        line_end      = pos_reg;

        // The first character of a line decides whether it is a comment.
        if (als_reg)
        begin
            als_next = 1'b0;
            if (beat.character == CH_HASH)
            begin
                cm_next = 1'b1;
            end
            else
            begin
                cm_next   = 1'b0;
                ls_next   = pos_reg;
                phase_cur = PH_HEAD;
            end
        end

        phase_next = phase_cur;

        if (cm_next)
        begin
            if (is_nl || last)
            begin
                cm_next    = 1'b0;
                phase_next = PH_HEAD;
                als_next   = 1'b1;
            end
        end
        else if (is_nl)
        begin
            finish   = 1'b1;
            line_end = pos_reg;
            als_next = 1'b1;
        end
        else
        begin
            case (phase_cur)
                PH_HEAD:
                begin
                    if (beat.character == CH_SPACE)
                    begin
                        hw_end_next = pos_reg;
                        phase_next  = PH_OPEN;
                    end
                end
                PH_OPEN:
                begin
                    if (beat.character == CH_OPEN)
                    begin
                        py_start_next = p_inc;
                        phase_next    = PH_CLOSE;
                    end
                end
                PH_CLOSE:
                begin
                    if (beat.character == CH_CLOSE)
                    begin
                        py_end_next = pos_reg;
                        phase_next  = PH_SLASH;
                    end
                end
                PH_SLASH:
                begin
                    if (beat.character == CH_SLASH)
                    begin
                        en_start_next = p_inc;
                        phase_next    = PH_SLASH2;
                    end
                end
                PH_SLASH2:
                begin
                    if (beat.character == CH_SLASH)
                    begin
                        en_end_next = pos_reg;
                        phase_next  = PH_ENGLISH;
                    end
                end
                PH_ENGLISH:
                begin
                    if (beat.character == CH_SLASH)
                    begin
                        en_end_next = pos_reg;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
            if (last)
            begin
                finish   = 1'b1;
                line_end = p_inc;
                als_next = 1'b1;
            end
        end

        // Only a line that saw every field separator produces an entry.
        emit = step && finish && (phase_next == PH_ENGLISH);
        if (finish)
        begin
            phase_next = PH_HEAD;
        end

        if (last)
        begin
            pos_next   = '0;
            als_next   = 1'b1;
            cm_next    = 1'b0;
            phase_next = PH_HEAD;
        end
        else
        begin
            pos_next = p_inc;
        end
    end

    assign result = '{
        entry_start:   ls_next,
        headword_end:  hw_end_next,
        pinyin_start:  py_start_next,
        pinyin_end:    py_end_next,
        english_start: en_start_next,
        english_end:   en_end_next,
        line_end:      line_end
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD;
            als_reg      <= 1'b1;
            cm_reg       <= 1'b0;
            pos_reg      <= '0;
            ls_reg       <= '0;
            hw_end_reg   <= '0;
            py_start_reg <= '0;
            py_end_reg   <= '0;
            en_start_reg <= '0;
            en_end_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            als_reg      <= als_next;
            cm_reg       <= cm_next;
            pos_reg      <= pos_next;
            ls_reg       <= ls_next;
            hw_end_reg   <= hw_end_next;
            py_start_reg <= py_start_next;
            py_end_reg   <= py_end_next;
            en_start_reg <= en_start_next;
            en_end_reg   <= en_end_next;
        end
    end

    `DLFS_ASSERT_NOW(a_comment_in_head, cm_reg, phase_reg == PH_HEAD,
        "Comment line left the headword phase.")
    `DLFS_ASSERT_NOW(a_emit_ends_line, emit, als_next && (phase_next == PH_HEAD),
        "Entry emitted without closing the line.")
    `DLFS_ASSERT_NEXT(a_pos_restart, step && last, pos_reg == '0,
        "Position did not restart after the last character.")
    `DLFS_ASSERT_NEXT(a_pos_count, step && !last, pos_reg == $past(pos_reg) + POS_W'(1),
        "Position did not advance by one.")

endmodule

// File: hdl/dlfs_out_stage.sv
// Output register holding one entry beat until the receiver takes it.
module dlfs_out_stage
    import dlfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dlfs_entry_if.source entries,
    input  logic         load,
    input  dlfs_result_t result,
    output logic         free
);

    logic         valid_reg;
    dlfs_result_t data_reg;

    assign free          = !valid_reg || entries.ready;
    assign entries.valid = valid_reg;

    assign entries.entry_start   = data_reg.entry_start;
    assign entries.headword_end  = data_reg.headword_end;
    assign entries.pinyin_start  = data_reg.pinyin_start;
    assign entries.pinyin_end    = data_reg.pinyin_end;
    assign entries.english_start = data_reg.english_start;
    assign entries.english_end   = data_reg.english_end;
    assign entries.line_end      = data_reg.line_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= result;
        end
    end

endmodule

// File: hdl/dictionary_line_field_splitter_core.sv
// Top level of the dictionary line field splitter.
//
// The chars channel takes one 16-bit text character per beat, with a flag that
// marks the last character of the buffer. The entries channel gives one beat per
// completed dictionary line: the positions of the line start, the headword end,
// the pinyin span, the English span and the point where the line ended.
// Comment lines and lines that lack one or more field separators give no beat.
// A character beat is taken into an input register and parsed from there once the
// output register is free; any entry is then loaded into the output register and
// is held there until the receiver takes it.
// The block takes one character per cycle for as long as the entries channel
// keeps up; it is bounded only by the parse step, which is combinational.
// When the receiver stalls, the output register holds its entry and the input
// register holds one character, after which chars.ready drops until the entry
// is taken.
// Reset empties both registers, sets the position to zero and starts a new line.
module dictionary_line_field_splitter_core
    import dlfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dlfs_char_if.sink    chars,
    dlfs_entry_if.source entries
);

    logic         held_valid;
    dlfs_char_t   held;
    logic         out_free;
    logic         step;
    logic         emit;
    dlfs_result_t result;

    assign step = held_valid && out_free;

    dlfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .advance    (out_free),
        .held_valid (held_valid),
        .held       (held)
    );

    dlfs_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (held),
        .emit   (emit),
        .result (result)
    );

    dlfs_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .entries (entries),
        .load    (emit),
        .result  (result),
        .free    (out_free)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the dictionary line field splitter: directed lines, random text, stalls.
`timescale 1ns / 1ps

module tb_top;
    import dlfs_pkg::*;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_ENTRY
    } row_kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        row_kind_t         kind;
        dlfs_result_t      ent;
    } script_row_t;

    localparam int SCRIPT_ROWS  = 26;
    localparam int RANDOM_BEATS = 1000;
    localparam int HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;

    dlfs_char_if  chars_if ();
    dlfs_entry_if entries_if ();

    dictionary_line_field_splitter_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .entries (entries_if)
    );

    // Model of the parser state.
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] line_first;
    logic [POS_W-1:0] hw_end;
    logic [POS_W-1:0] py_start;
    logic [POS_W-1:0] py_end;
    logic [POS_W-1:0] en_start;
    logic [POS_W-1:0] en_end;
    dlfs_phase_t      line_phase;
    bit               awaiting_first;
    bit               skipping_comment;

    dlfs_result_t pending_entries[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;
    int beats_sent;
    int entries_seen;
    int lines_sent;
    int comment_lines;
    int fails;

    logic [CHAR_W-1:0] separators[6];
    string             field_names[7];
    dlfs_result_t      want_ent;
    dlfs_result_t      got_ent;

    script_row_t dir_script[SCRIPT_ROWS] = '{
        '{CH_NEWLINE, 1'b0, ROW_NONE,    '0},
        '{CH_SPACE,   1'b0, ROW_PREDICT, '0},
        '{CH_OPEN,    1'b0, ROW_PREDICT, '0},
        '{CH_CLOSE,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b0, ROW_PREDICT, '0},
        '{CH_NEWLINE, 1'b0, ROW_ENTRY,
          '{24'd1, 24'd1, 24'd3, 24'd3, 24'd5, 24'd5, 24'd6}},
        '{CH_HASH,    1'b0, ROW_NONE,    '0},
        '{CH_SLASH,   1'b0, ROW_NONE,    '0},
        '{CH_NEWLINE, 1'b0, ROW_NONE,    '0},
        '{16'hFFFF,   1'b0, ROW_PREDICT, '0},
        '{CH_SPACE,   1'b0, ROW_PREDICT, '0},
        '{CH_OPEN,    1'b0, ROW_PREDICT, '0},
        '{CH_CLOSE,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b0, ROW_PREDICT, '0},
        '{16'h0000,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b1, ROW_ENTRY,
          '{24'd10, 24'd11, 24'd13, 24'd13, 24'd15, 24'd17, 24'd18}},
        '{CH_HASH,    1'b0, ROW_NONE,    '0},
        '{16'h0078,   1'b1, ROW_NONE,    '0},
        '{CH_SPACE,   1'b0, ROW_PREDICT, '0},
        '{CH_OPEN,    1'b0, ROW_PREDICT, '0},
        '{CH_CLOSE,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b0, ROW_PREDICT, '0},
        '{CH_SLASH,   1'b0, ROW_PREDICT, '0},
        '{CH_NEWLINE, 1'b1, ROW_ENTRY,
          '{24'd0, 24'd0, 24'd2, 24'd2, 24'd4, 24'd4, 24'd5}}
    };

    function automatic bit close_line(input logic [POS_W-1:0] end_pos,
                                      output dlfs_result_t ent);
        bit hit;
        hit = (line_phase == PH_ENGLISH);
        ent = '{line_first, hw_end, py_start, py_end, en_start, en_end, end_pos};
        line_phase = PH_HEAD;
        awaiting_first = 1'b1;
        return hit;
    endfunction

    function automatic bit split_char(input logic [CHAR_W-1:0] ch, input bit last_flag,
                                      output dlfs_result_t ent);
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] p_next;
        bit               last;
        bit               hit;
        p = cur_pos;
        p_next = p + 1'b1;
        last = last_flag;
        hit = 1'b0;
        ent = '0;
        if (BUF_END_REACHABLE && p == BUF_LAST_POS)
            last = 1'b1;
        if (awaiting_first)
        begin
            awaiting_first = 1'b0;
            if (ch == CH_HASH)
                skipping_comment = 1'b1;
            else
            begin
                skipping_comment = 1'b0;
                line_first = p;
                line_phase = PH_HEAD;
            end
        end
        if (skipping_comment)
        begin
            if (ch == CH_NEWLINE || last)
            begin
                skipping_comment = 1'b0;
                line_phase = PH_HEAD;
                awaiting_first = 1'b1;
            end
        end
        else if (ch == CH_NEWLINE)
            hit = close_line(p, ent);
        else
        begin
            case (line_phase)
                PH_HEAD:
                    if (ch == CH_SPACE)
                    begin
                        hw_end = p;
                        line_phase = PH_OPEN;
                    end
                PH_OPEN:
                    if (ch == CH_OPEN)
                    begin
                        py_start = p_next;
                        line_phase = PH_CLOSE;
                    end
                PH_CLOSE:
                    if (ch == CH_CLOSE)
                    begin
                        py_end = p;
                        line_phase = PH_SLASH;
                    end
                PH_SLASH:
                    if (ch == CH_SLASH)
                    begin
                        en_start = p_next;
                        line_phase = PH_SLASH2;
                    end
                PH_SLASH2:
                    if (ch == CH_SLASH)
                    begin
                        en_end = p;
                        line_phase = PH_ENGLISH;
                    end
                default:
                    if (ch == CH_SLASH)
                        en_end = p;
            endcase
            if (last)
                hit = close_line(p_next, ent);
        end
        if (last)
        begin
            cur_pos = '0;
            awaiting_first = 1'b1;
            skipping_comment = 1'b0;
            line_phase = PH_HEAD;
        end
        else
            cur_pos = p_next;
        return hit;
    endfunction

    task automatic send_beat(input logic [CHAR_W-1:0] ch, input bit last,
                             input row_kind_t kind, input dlfs_result_t typed);
        dlfs_result_t ent;
        bit           hit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid          <= 1'b1;
        chars_if.character      <= ch;
        chars_if.last_in_buffer <= last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        beats_sent++;
        hit = split_char(ch, last, ent);
        if (kind == ROW_ENTRY)
            pending_entries = {pending_entries, typed};
        else if (kind == ROW_PREDICT && hit)
            pending_entries = {pending_entries, ent};
    endtask

    function automatic logic [CHAR_W-1:0] text_char();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return CHAR_W'($urandom_range(16'hFFFF));
        if (r < 8)
            return separators[$urandom_range(5)];
        return CHAR_W'($urandom_range(16'h7A, 16'h61));
    endfunction

    task automatic send_line();
        logic [CHAR_W-1:0] line_q[$];
        int                kind;
        int                skip;
        int                r;
        int                segs;
        bit                flag_last;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            // Well-formed entries mostly; otherwise one separator is left out.
            skip = (kind < 70) ? 5 : $urandom_range(4);
            repeat ($urandom_range(4, 1)) line_q = {line_q, text_char()};
            if (skip != 0) line_q = {line_q, CH_SPACE};
            repeat ($urandom_range(2)) line_q = {line_q, text_char()};
            if (skip != 1) line_q = {line_q, CH_OPEN};
            repeat ($urandom_range(4)) line_q = {line_q, text_char()};
            if (skip != 2) line_q = {line_q, CH_CLOSE};
            repeat ($urandom_range(2)) line_q = {line_q, text_char()};
            if (skip != 3) line_q = {line_q, CH_SLASH};
            segs = $urandom_range(3, 1);
            repeat (segs)
            begin
                repeat ($urandom_range(4)) line_q = {line_q, text_char()};
                if (skip != 4) line_q = {line_q, CH_SLASH};
            end
            repeat ($urandom_range(2)) line_q = {line_q, text_char()};
        end
        else if (kind < 88)
        begin
            comment_lines++;
            line_q = {line_q, CH_HASH};
            repeat ($urandom_range(8)) line_q = {line_q, text_char()};
        end
        else if (kind >= 93)
            repeat ($urandom_range(12, 1))
                line_q = {line_q, CHAR_W'($urandom_range(16'hFFFF))};
        r = $urandom_range(99);
        flag_last = 1'b0;
        if (r < 90)
            line_q = {line_q, CH_NEWLINE};
        else if (r < 95 || line_q.size() == 0)
        begin
            line_q = {line_q, CH_NEWLINE};
            flag_last = (r < 95);
        end
        else
            flag_last = 1'b1;
        lines_sent++;
        foreach (line_q[i])
            send_beat(line_q[i], flag_last && i == line_q.size() - 1, ROW_PREDICT, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("dictionary_line_field_splitter_core: mismatch");
        $finish;
    end

    initial
    begin
        entries_if.ready = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                entries_if.ready <= 1'b0;
            end
            else
                entries_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && entries_if.valid && entries_if.ready)
        begin
            entries_seen++;
            got_ent = '{entries_if.entry_start, entries_if.headword_end,
                        entries_if.pinyin_start, entries_if.pinyin_end,
                        entries_if.english_start, entries_if.english_end,
                        entries_if.line_end};
            if (pending_entries.size() == 0)
            begin
                $error("entry beat with none outstanding: line_end %0d", got_ent.line_end);
                fails++;
            end
            else
            begin
                want_ent = pending_entries.pop_front();
                for (int i = 0; i < 7; i++)
                begin
                    if (got_ent[(6-i)*POS_W +: POS_W] !== want_ent[(6-i)*POS_W +: POS_W])
                    begin
                        $error("%s: expected %0d, got %0d", field_names[i],
                               want_ent[(6-i)*POS_W +: POS_W], got_ent[(6-i)*POS_W +: POS_W]);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        separators = '{CH_NEWLINE, CH_HASH, CH_SPACE, CH_OPEN, CH_CLOSE, CH_SLASH};
        field_names = '{"entry_start", "headword_end", "pinyin_start", "pinyin_end",
                        "english_start", "english_end", "line_end"};
        chars_if.valid = 1'b0;
        chars_if.character = '0;
        chars_if.last_in_buffer = 1'b0;
        rst_n = 1'b0;
        hold_req = 1'b0;
        beats_sent = 0;
        entries_seen = 0;
        lines_sent = 0;
        comment_lines = 0;
        fails = 0;
        cur_pos = '0;
        line_first = '0;
        hw_end = '0;
        py_start = '0;
        py_end = '0;
        en_start = '0;
        en_end = '0;
        line_phase = PH_HEAD;
        awaiting_first = 1'b1;
        skipping_comment = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 76;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_script[i])
            send_beat(dir_script[i].ch, dir_script[i].last, dir_script[i].kind,
                      dir_script[i].ent);

        while (beats_sent < SCRIPT_ROWS + RANDOM_BEATS)
        begin
            if (beats_sent >= SCRIPT_ROWS + 2 * RANDOM_BEATS / 3 && send_idle_pct != 0)
            begin
                // The long output stall makes the block back up into its input.
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req = 1'b1;
            end
            else if (beats_sent >= SCRIPT_ROWS + RANDOM_BEATS / 3 && send_idle_pct == 17)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 17;
            end
            send_line();
        end
        chars_if.valid <= 1'b0;

        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d character beats in %0d random lines (%0d comment lines).",
                 beats_sent, lines_sent, comment_lines);
        $display("Checked %0d entry beats under both stall mixes and one long output stall.",
                 entries_seen);
        if (fails == 0 && pending_entries.size() == 0)
            $display("dictionary_line_field_splitter_core: match");
        else
            $display("dictionary_line_field_splitter_core: mismatch");
        $finish;
    end

endmodule
